### rtl/ipv4_flow_traffic_counter_defines.svh
// Assertion macros used by the flow counter probe engine.
`ifndef IPV4_FLOW_TRAFFIC_COUNTER_DEFINES_SVH
`define IPV4_FLOW_TRAFFIC_COUNTER_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled while arst_n is low.
`define FTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, disabled while arst_n is low.
`define FTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ftc_pkg.sv
// Shared types and constants of the IPv4 flow traffic counter.
`timescale 1ns / 1ps

package ftc_pkg;

	localparam logic [15:0] ETH_HEADER_BYTES = 16'd14;
	localparam logic [15:0] IPV4_MIN_FRAME   = 16'd34;
	localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;

	typedef enum logic [1:0] {
		ST_SKIP = 2'd0,
		ST_HIT  = 2'd1,
		ST_NEW  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// One table entry as it sits in the flow memory
	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [63:0] tx_pkt;
		logic [63:0] rx_pkt;
		logic [63:0] tx_byte;
		logic [63:0] rx_byte;
	} entry_t;

	// Result handed from the probe engine to the output register
	typedef struct packed {
		status_t     status;
		logic [63:0] tx_pkt;
		logic [63:0] rx_pkt;
		logic [63:0] tx_byte;
		logic [63:0] rx_byte;
	} res_t;

endpackage

### rtl/ftc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module ftc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/ftc_hash.sv
// Packet filter, flow key build and home index hash.
`timescale 1ns / 1ps

module ftc_hash #(
	parameter int TABLE_ENTRIES = 2048,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic             is_receive,
	input  logic [15:0]      frame_length,
	input  logic [15:0]      ether_type,
	input  logic [31:0]      source_address,
	input  logic [31:0]      destination_address,
	output logic             counted,
	output logic [63:0]      key,
	output logic [IDX_W-1:0] home_idx
);

	logic [IDX_W-1:0] fold;
	logic [IDX_W:0]   fold_x;

	// Short or non-IPv4 frames are not counted
	assign counted = (frame_length >= ftc_pkg::ETH_HEADER_BYTES)
		&& (ether_type == ftc_pkg::ETHERTYPE_IPV4)
		&& (frame_length >= ftc_pkg::IPV4_MIN_FRAME);

	// Key is (local, remote)
	assign key = is_receive ? {destination_address, source_address}
	                        : {source_address, destination_address};

	// XOR-fold the key down to the index width
	always_comb begin
		fold = '0;
		for (int b = 0; b < 64; b++) begin
			fold[b % IDX_W] = fold[b % IDX_W] ^ key[b];
		end
	end

	// Fold is below twice the table size, so one subtract brings it in range
	assign fold_x = {1'b0, fold};
	always_comb begin
		if (fold_x >= (IDX_W+1)'(TABLE_ENTRIES)) begin
			home_idx = IDX_W'(fold_x - (IDX_W+1)'(TABLE_ENTRIES));
		end else begin
			home_idx = fold;
		end
	end

endmodule

### rtl/ftc_probe_ctrl.sv
// Linear-probe engine: clearing pass, lookup, counter update and insert.
`timescale 1ns / 1ps
`include "ipv4_flow_traffic_counter_defines.svh"

module ftc_probe_ctrl #(
	parameter int TABLE_ENTRIES = 2048,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              is_receive,
	input  logic [15:0]       frame_length,
	input  logic              counted,
	input  logic [63:0]       key,
	input  logic [IDX_W-1:0]  home_idx,
	input  logic              res_free,
	output logic              res_push,
	output ftc_pkg::res_t     res
);

	localparam int ENTRY_W = $bits(ftc_pkg::entry_t);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   probe_idx_q;
	logic [IDX_W-1:0]   probes_q;
	logic [CNT_W-1:0]   used_q;
	logic [63:0]        key_q;
	logic               rx_q;
	logic [15:0]        len_q;
	ftc_pkg::res_t      res_q;

	logic               in_xfer;
	logic [IDX_W-1:0]   idx_next;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;
	logic [ENTRY_W-1:0] wr_data;
	ftc_pkg::entry_t    ent;
	ftc_pkg::entry_t    upd;
	ftc_pkg::entry_t    ins;
	logic               hit;
	logic               empty;
	logic               last_probe;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign res_push = (state_q == S_DONE) && res_free;
	assign res      = res_q;

	// Probe sequence wraps at the table end
	assign idx_next = (probe_idx_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0
	                                                              : probe_idx_q + 1'b1;

	assign ent        = ftc_pkg::entry_t'(rd_data);
	assign hit        = ent.valid && (ent.key == key_q);
	assign empty      = !ent.valid;
	assign last_probe = (probes_q == IDX_W'(TABLE_ENTRIES - 1));

	// Updated entry on a hit
	always_comb begin
		upd = ent;
		if (rx_q) begin
			upd.rx_pkt  = ent.rx_pkt + 64'd1;
			upd.rx_byte = ent.rx_byte + {48'b0, len_q};
		end else begin
			upd.tx_pkt  = ent.tx_pkt + 64'd1;
			upd.tx_byte = ent.tx_byte + {48'b0, len_q};
		end
	end

	// Fresh entry on an insert
	always_comb begin
		ins.valid   = 1'b1;
		ins.key     = key_q;
		ins.tx_pkt  = rx_q ? 64'd0 : 64'd1;
		ins.rx_pkt  = rx_q ? 64'd1 : 64'd0;
		ins.tx_byte = rx_q ? 64'd0 : {48'b0, len_q};
		ins.rx_byte = rx_q ? {48'b0, len_q} : 64'd0;
	end

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_next;
		wr_en   = 1'b0;
		wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				rd_en   = in_xfer && counted;
				rd_addr = home_idx;
			end
			S_CHECK: begin
				if (hit) begin
					wr_en   = 1'b1;
					wr_data = ENTRY_W'(upd);
				end else if (empty) begin
					wr_en   = 1'b1;
					wr_data = ENTRY_W'(ins);
				end else begin
					rd_en = !last_probe;
				end
			end
			default: begin
			end
		endcase
	end

	ftc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_flow_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (probe_idx_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			probe_idx_q <= '0;
			probes_q    <= '0;
			used_q      <= '0;
			key_q       <= '0;
			rx_q        <= 1'b0;
			len_q       <= '0;
			res_q       <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					probe_idx_q <= idx_next;
					if (probe_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						key_q       <= key;
						rx_q        <= is_receive;
						len_q       <= frame_length;
						probe_idx_q <= home_idx;
						probes_q    <= '0;
						if (counted) begin
							state_q <= S_CHECK;
						end else begin
							res_q   <= '{status: ftc_pkg::ST_SKIP, default: '0};
							state_q <= S_DONE;
						end
					end
				end
				S_CHECK: begin
					if (hit) begin
						res_q <= '{status: ftc_pkg::ST_HIT, tx_pkt: upd.tx_pkt,
						           rx_pkt: upd.rx_pkt, tx_byte: upd.tx_byte,
						           rx_byte: upd.rx_byte};
						state_q <= S_DONE;
					end else if (empty) begin
						res_q <= '{status: ftc_pkg::ST_NEW, tx_pkt: ins.tx_pkt,
						           rx_pkt: ins.rx_pkt, tx_byte: ins.tx_byte,
						           rx_byte: ins.rx_byte};
						used_q  <= used_q + 1'b1;
						state_q <= S_DONE;
					end else if (last_probe) begin
						// Every entry holds another key: table full
						res_q   <= '{status: ftc_pkg::ST_FULL, default: '0};
						state_q <= S_DONE;
					end else begin
						probe_idx_q <= idx_next;
						probes_q    <= probes_q + 1'b1;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FTC_ASSERT_NOW(a_used_bound, 1'b1, used_q <= CNT_W'(TABLE_ENTRIES), "fill count above table size")
	`FTC_ASSERT_NOW(a_wr_state, wr_en, (state_q == S_CLEAR) || (state_q == S_CHECK), "memory write outside clear or check")
	`FTC_ASSERT_NEXT(a_insert_count, (state_q == S_CHECK) && !hit && empty, used_q == $past(used_q) + 1'b1, "insert did not bump fill count")
	`FTC_ASSERT_NOW(a_full_only, (state_q == S_CHECK) && empty, used_q < CNT_W'(TABLE_ENTRIES), "empty entry found in a full table")

endmodule

### rtl/ipv4_flow_traffic_counter.sv
// Top level of the IPv4 per-flow packet and byte counter.
`timescale 1ns / 1ps

// After an input transfer the engine makes P flow RAM probes, then moves the result
// to the output register, where P is 0 if the packet is not counted, else 1 to
// TABLE_ENTRIES. No new input is taken until the engine has handed its result on.
// A result waiting in the output register does not block the next input.
// Reset: asynchronous; a clearing pass over all TABLE_ENTRIES entries then runs,
// with no input taken, to mark every table entry empty.

module ipv4_flow_traffic_counter #(
	parameter int TABLE_ENTRIES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        is_receive,
	input  logic [15:0] frame_length,
	input  logic [15:0] ether_type,
	input  logic [31:0] source_address,
	input  logic [31:0] destination_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [63:0] tx_packet_total,
	output logic [63:0] rx_packet_total,
	output logic [63:0] tx_byte_total,
	output logic [63:0] rx_byte_total
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic             counted;
	logic [63:0]      key;
	logic [IDX_W-1:0] home_idx;
	logic             res_free;
	logic             res_push;
	ftc_pkg::res_t    res;
	logic             out_valid_q;
	ftc_pkg::res_t    out_q;

	ftc_hash #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_hash (
		.is_receive          (is_receive),
		.frame_length        (frame_length),
		.ether_type          (ether_type),
		.source_address      (source_address),
		.destination_address (destination_address),
		.counted             (counted),
		.key                 (key),
		.home_idx            (home_idx)
	);

	ftc_probe_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.is_receive   (is_receive),
		.frame_length (frame_length),
		.counted      (counted),
		.key          (key),
		.home_idx     (home_idx),
		.res_free     (res_free),
		.res_push     (res_push),
		.res          (res)
	);

	// Output register: free when empty or being drained this cycle
	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign tx_packet_total = out_q.tx_pkt;
	assign rx_packet_total = out_q.rx_pkt;
	assign tx_byte_total   = out_q.tx_byte;
	assign rx_byte_total   = out_q.rx_byte;

endmodule
